// File: src/hpc_pkg.sv
package hpc_pkg;

  // Field widths.
  localparam int RW    = 24;  // radius and ratio registers
  localparam int PW    = 32;  // phase input
  localparam int TW    = 16;  // bits of one turn
  localparam int OW    = 25;  // output coordinates
  localparam int IW    = 2;   // register index
  localparam int GUARD = 8;   // guard bits below the radius LSB

  // Datapath widths: vectors, angle accumulator and final sums.
  localparam int XW = 35;
  localparam int ZW = 34;
  localparam int SW = XW + 1;

  // Reciprocal of the CORDIC gain, scaled by 2^32.
  localparam logic [31:0] CORDIC_GAIN = 32'h9B74EDA8;

  // atan(2^-i) in units of 2^-32 turn.
  localparam logic [31:0] ATAN_TAB [24] = '{
    32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C, 32'h000028BE, 32'h0000145F,
    32'h00000A2F, 32'h00000517, 32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
  };

  // Register indexes.
  localparam logic [IW-1:0] REG_OUTER = 2'd0;
  localparam logic [IW-1:0] REG_INNER = 2'd1;
  localparam logic [IW-1:0] REG_RATIO = 2'd2;

  // Start vector and angle for one rotator.
  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [ZW-1:0] z;
  } rot_in_t;

endpackage

// File: src/hypocycloid_point_top.sv
// Hypocycloid point generator. Software writes the outer radius R, the rolling
// radius r and the ratio k = R/r - 1 (all unsigned Q8.16) while the block is
// idle; each accepted phase then yields one point, x = (R-r)cos t + r cos(kt)
// and y = (R-r)sin t - r sin(kt), as signed Q8.16 saturated to 25 bits. busy
// stays low, so a new phase is taken on every cycle that start is high. Each
// point appears on done_o for one cycle, in the order taken, after its phase
// has passed the pipeline: one stage for the k*t product and gain scaling, one
// for angle folding, one per CORDIC micro-rotation and one for the final add,
// rounding and clamp. The receiver cannot stall the pipeline and must take
// each point when it comes.
module hypocycloid_point_top #(
  parameter int CORDIC_STAGES = 16,
  parameter int FRAC_BITS     = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic [hpc_pkg::PW-1:0]         phase_i,
  output logic                           done_o,
  output logic signed [hpc_pkg::OW-1:0]  point_x_o,
  output logic signed [hpc_pkg::OW-1:0]  point_y_o,
  input  logic                           cfg_we_i,
  input  logic [hpc_pkg::IW-1:0]         cfg_idx_i,
  input  logic [hpc_pkg::RW-1:0]         cfg_data_i
);

  localparam int XW  = hpc_pkg::XW;
  localparam int LAT = CORDIC_STAGES + 3;

  logic [hpc_pkg::RW-1:0] outer_q;
  logic [hpc_pkg::RW-1:0] inner_q;
  logic [hpc_pkg::RW-1:0] ratio_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outer_q <= '0;
      inner_q <= '0;
      ratio_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        hpc_pkg::REG_OUTER: outer_q <= cfg_data_i;
        hpc_pkg::REG_INNER: inner_q <= cfg_data_i;
        hpc_pkg::REG_RATIO: ratio_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  logic             front_valid;
  hpc_pkg::rot_in_t rot_a;
  hpc_pkg::rot_in_t rot_b;

  hpc_front #(
    .FRAC_BITS(FRAC_BITS)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start && !busy),
    .phase_i (phase_i),
    .outer_i (outer_q),
    .inner_i (inner_q),
    .ratio_i (ratio_q),
    .valid_o (front_valid),
    .rot_a_o (rot_a),
    .rot_b_o (rot_b)
  );

  logic                 va;
  logic                 vb;
  logic signed [XW-1:0] xa;
  logic signed [XW-1:0] ya;
  logic signed [XW-1:0] xb;
  logic signed [XW-1:0] yb;

  hpc_cordic #(
    .CORDIC_STAGES(CORDIC_STAGES)
  ) u_cordic_a (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (front_valid),
    .rot_i   (rot_a),
    .valid_o (va),
    .x_o     (xa),
    .y_o     (ya)
  );

  hpc_cordic #(
    .CORDIC_STAGES(CORDIC_STAGES)
  ) u_cordic_b (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (front_valid),
    .rot_i   (rot_b),
    .valid_o (vb),
    .x_o     (xb),
    .y_o     (yb)
  );

  hpc_combine u_combine (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (va && vb),
    .xa_i      (xa),
    .ya_i      (ya),
    .xb_i      (xb),
    .yb_i      (yb),
    .valid_o   (done_o),
    .point_x_o (point_x_o),
    .point_y_o (point_y_o)
  );

  // The two rotators must run in lockstep.
  a_rot_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    va == vb)
    else $error("rotator valid bits disagree");

  // Every accepted item comes out after the fixed latency.
  a_item_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##LAT done_o)
    else $error("accepted item not delivered on time");

  // No result without an item accepted the fixed latency earlier.
  a_no_ghost: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, LAT))
    else $error("result strobe without an accepted item");

endmodule

// File: src/hpc_front.sv
module hpc_front #(
  parameter int FRAC_BITS = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  input  logic [hpc_pkg::PW-1:0]   phase_i,
  input  logic [hpc_pkg::RW-1:0]   outer_i,
  input  logic [hpc_pkg::RW-1:0]   inner_i,
  input  logic [hpc_pkg::RW-1:0]   ratio_i,
  output logic                     valid_o,
  output hpc_pkg::rot_in_t         rot_a_o,
  output hpc_pkg::rot_in_t         rot_b_o
);

  localparam int RW  = hpc_pkg::RW;
  localparam int PW  = hpc_pkg::PW;
  localparam int TW  = hpc_pkg::TW;
  localparam int XW  = hpc_pkg::XW;
  localparam int ZW  = hpc_pkg::ZW;
  localparam int MW  = RW + PW;
  localparam int GPW = RW + 1 + 33;

  // Stage one: k*t product and the gain-scaled start amplitudes.
  logic [MW-1:0]          kprod;
  logic signed [RW:0]     amp_a;
  logic signed [RW:0]     amp_b;
  logic signed [GPW-1:0]  gain_ext;
  logic signed [GPW-1:0]  prod_a;
  logic signed [GPW-1:0]  prod_b;

  assign kprod    = MW'(ratio_i) * MW'(phase_i);
  assign amp_a    = $signed({1'b0, outer_i}) - $signed({1'b0, inner_i});
  assign amp_b    = $signed({1'b0, inner_i});
  assign gain_ext = GPW'(hpc_pkg::CORDIC_GAIN);
  assign prod_a   = GPW'(amp_a) * gain_ext;
  assign prod_b   = GPW'(amp_b) * gain_ext;

  logic                 v1_q;
  logic [TW-1:0]        t1_q;
  logic [TW-1:0]        kt1_q;
  logic signed [XW-1:0] xa1_q;
  logic signed [XW-1:0] xb1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    t1_q  <= phase_i[TW-1:0];
    kt1_q <= kprod[FRAC_BITS +: TW];
    xa1_q <= XW'(prod_a >>> (32 - hpc_pkg::GUARD));
    xb1_q <= XW'(prod_b >>> (32 - hpc_pkg::GUARD));
  end

  // Stage two: fold the angle into [-1/4, 1/4) turn. In the second and third
  // quarters the vector is negated and the angle moves by half a turn, which
  // leaves the sign of the folded angle equal to bit 14.
  function automatic hpc_pkg::rot_in_t fold(input logic [TW-1:0] a,
                                            input logic signed [XW-1:0] x);
    hpc_pkg::rot_in_t r;
    logic             neg;
    neg = a[TW-1] ^ a[TW-2];
    r.x = neg ? -x : x;
    r.z = {{(ZW-32){a[TW-2]}}, a[TW-2], a[TW-2:0], 16'b0};
    return r;
  endfunction

  logic             v2_q;
  hpc_pkg::rot_in_t rot_a_q;
  hpc_pkg::rot_in_t rot_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    rot_a_q <= fold(t1_q, xa1_q);
    rot_b_q <= fold(kt1_q, xb1_q);
  end

  assign valid_o = v2_q;
  assign rot_a_o = rot_a_q;
  assign rot_b_o = rot_b_q;

endmodule

// File: src/hpc_cordic.sv
module hpc_cordic #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  input  hpc_pkg::rot_in_t               rot_i,
  output logic                           valid_o,
  output logic signed [hpc_pkg::XW-1:0]  x_o,
  output logic signed [hpc_pkg::XW-1:0]  y_o
);

  localparam int XW = hpc_pkg::XW;
  localparam int ZW = hpc_pkg::ZW;

  logic signed [XW-1:0]     x_q [CORDIC_STAGES];
  logic signed [XW-1:0]     y_q [CORDIC_STAGES];
  logic signed [ZW-1:0]     z_q [CORDIC_STAGES];
  logic [CORDIC_STAGES-1:0] v_q;

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
    logic signed [XW-1:0] xp;
    logic signed [XW-1:0] yp;
    logic signed [ZW-1:0] zp;
    logic                 vp;
    logic signed [ZW-1:0] atan;

    if (i == 0) begin : g_first
      assign xp = rot_i.x;
      assign yp = '0;
      assign zp = rot_i.z;
      assign vp = valid_i;
    end else begin : g_next
      assign xp = x_q[i-1];
      assign yp = y_q[i-1];
      assign zp = z_q[i-1];
      assign vp = v_q[i-1];
    end

    assign atan = ZW'(hpc_pkg::ATAN_TAB[i]);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i] <= 1'b0;
      end else begin
        v_q[i] <= vp;
      end
    end

    // Rotate toward zero residual angle; shifts floor like the arithmetic shift.
    always_ff @(posedge clk_i) begin
      if (!zp[ZW-1]) begin
        x_q[i] <= xp - (yp >>> i);
        y_q[i] <= yp + (xp >>> i);
        z_q[i] <= zp - atan;
      end else begin
        x_q[i] <= xp + (yp >>> i);
        y_q[i] <= yp - (xp >>> i);
        z_q[i] <= zp + atan;
      end
    end
  end

  assign valid_o = v_q[CORDIC_STAGES-1];
  assign x_o     = x_q[CORDIC_STAGES-1];
  assign y_o     = y_q[CORDIC_STAGES-1];

endmodule

// File: src/hpc_combine.sv
module hpc_combine (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  input  logic signed [hpc_pkg::XW-1:0]  xa_i,
  input  logic signed [hpc_pkg::XW-1:0]  ya_i,
  input  logic signed [hpc_pkg::XW-1:0]  xb_i,
  input  logic signed [hpc_pkg::XW-1:0]  yb_i,
  output logic                           valid_o,
  output logic signed [hpc_pkg::OW-1:0]  point_x_o,
  output logic signed [hpc_pkg::OW-1:0]  point_y_o
);

  localparam int SW = hpc_pkg::SW;
  localparam int OW = hpc_pkg::OW;
  localparam logic signed [SW-1:0] HALF = SW'(1) << (hpc_pkg::GUARD - 1);

  // Round half up to the output LSB, then clamp to the field range.
  function automatic logic signed [OW-1:0] round_sat(input logic signed [SW-1:0] s);
    logic signed [SW-1:0] r;
    logic signed [SW-1:0] q;
    logic signed [OW-1:0] res;
    r = s + HALF;
    q = r >>> hpc_pkg::GUARD;
    if ((&q[SW-1:OW-1]) || !(|q[SW-1:OW-1])) begin
      res = q[OW-1:0];
    end else if (q[SW-1]) begin
      res = {1'b1, {(OW-1){1'b0}}};
    end else begin
      res = {1'b0, {(OW-1){1'b1}}};
    end
    return res;
  endfunction

  logic signed [SW-1:0] sum_x;
  logic signed [SW-1:0] sum_y;

  assign sum_x = SW'(xa_i) + SW'(xb_i);
  assign sum_y = SW'(ya_i) - SW'(yb_i);

  logic                 v_q;
  logic signed [OW-1:0] px_q;
  logic signed [OW-1:0] py_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    px_q <= round_sat(sum_x);
    py_q <= round_sat(sum_y);
  end

  assign valid_o   = v_q;
  assign point_x_o = px_q;
  assign point_y_o = py_q;

endmodule

// File: sim/hypocycloid_point_checker.sv
module hypocycloid_point_checker #(
  parameter int CORDIC_STAGES = 16,
  parameter int FRAC_BITS     = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic                           busy_i,
  input  logic [hpc_pkg::PW-1:0]         phase_i,
  input  logic                           cfg_we_i,
  input  logic [hpc_pkg::IW-1:0]         cfg_idx_i,
  input  logic [hpc_pkg::RW-1:0]         cfg_data_i,
  input  logic                           done_i,
  input  logic signed [hpc_pkg::OW-1:0]  point_x_i,
  input  logic signed [hpc_pkg::OW-1:0]  point_y_i,
  output int                             mismatch_cnt_o,
  output int                             pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PW = hpc_pkg::PW;
  localparam int RW = hpc_pkg::RW;
  localparam int TW = hpc_pkg::TW;
  localparam int OW = hpc_pkg::OW;

  localparam int          GUARD_BITS     = 8;
  localparam longint      INV_GAIN       = 64'h9B74EDA8;
  localparam logic [15:0] QUARTER        = 16'h4000;
  localparam logic [15:0] THREE_QUARTERS = 16'hC000;
  localparam longint      HALF_TURN      = 32768;
  localparam longint      FULL_TURN      = 65536;
  localparam longint      SAT_HI         = 64'sd16777215;
  localparam longint      SAT_LO         = -64'sd16777216;
  localparam int          REPORT_LIMIT   = 10;

  // Arctangent of 2^-i in units of 2^-32 turn, truncated.
  localparam logic [31:0] ARCTAN_LUT [24] = '{
    32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C, 32'h000028BE, 32'h0000145F,
    32'h00000A2F, 32'h00000517, 32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
  };

  typedef struct packed {
    logic signed [OW-1:0] x;
    logic signed [OW-1:0] y;
  } point_t;

  point_t        point_q [$];
  logic [RW-1:0] outer_r;
  logic [RW-1:0] inner_r;
  logic [RW-1:0] ratio;
  int            point_idx;

  // Rotates (amp, 0) by a 16-bit turn angle; the result keeps the guard bits.
  function automatic void rotate_vec(input longint amp, input logic [TW-1:0] ang16,
                                     output longint xo, output longint yo);
    longint x;
    longint y;
    longint z;
    longint ang;
    longint dx;
    longint dy;
    x   = (amp * INV_GAIN) >>> (32 - GUARD_BITS);
    y   = 0;
    ang = {48'd0, ang16};
    // Angles in the left half plane start from the negated vector.
    if (ang16 >= QUARTER && ang16 < THREE_QUARTERS) begin
      x   = -x;
      ang = ang - HALF_TURN;
    end else if (ang16 >= THREE_QUARTERS) begin
      ang = ang - FULL_TURN;
    end
    z = ang <<< 16;
    for (int i = 0; i < CORDIC_STAGES && i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - longint'(ARCTAN_LUT[i]);
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + longint'(ARCTAN_LUT[i]);
      end
    end
    xo = x;
    yo = y;
  endfunction

  function automatic logic signed [OW-1:0] round_clamp(input longint v);
    longint r;
    r = (v + (64'sd1 <<< (GUARD_BITS - 1))) >>> GUARD_BITS;
    if (r > SAT_HI) r = SAT_HI;
    if (r < SAT_LO) r = SAT_LO;
    return r[OW-1:0];
  endfunction

  function automatic point_t predict_point(input logic [PW-1:0] ph);
    logic [55:0]   prod;
    logic [TW-1:0] t;
    logic [TW-1:0] kt;
    longint        d;
    longint        x1;
    longint        y1;
    longint        x2;
    longint        y2;
    point_t        p;
    prod = ratio * ph;
    t    = ph[TW-1:0];
    kt   = prod[FRAC_BITS +: TW];
    d    = longint'({40'd0, outer_r}) - longint'({40'd0, inner_r});
    rotate_vec(d, t, x1, y1);
    rotate_vec({40'd0, inner_r}, kt, x2, y2);
    p.x = round_clamp(x1 + x2);
    p.y = round_clamp(y1 - y2);
    return p;
  endfunction

  always @(posedge clk_i) begin : watch
    point_t want;
    if (!rst_ni) begin
      point_q.delete();
      outer_r        = '0;
      inner_r        = '0;
      ratio          = '0;
      point_idx      = 0;
      mismatch_cnt_o = 0;
    end else begin
      if (done_i) begin
        if (point_q.size() == 0) begin
          mismatch_cnt_o++;
          if (mismatch_cnt_o <= REPORT_LIMIT)
            $display("unexpected point x %0d y %0d", point_x_i, point_y_i);
        end else begin
          want = point_q[0];
          point_q.delete(0);
          if (point_x_i !== want.x || point_y_i !== want.y) begin
            mismatch_cnt_o++;
            if (mismatch_cnt_o <= REPORT_LIMIT)
              $display("point %0d: x expected %0d got %0d, y expected %0d got %0d",
                       point_idx, want.x, point_x_i, want.y, point_y_i);
          end
        end
        point_idx++;
      end
      // The item taken at this edge still sees the registers before any write.
      if (start_i && !busy_i) point_q.insert(point_q.size(), predict_point(phase_i));
      if (cfg_we_i) begin
        case (cfg_idx_i)
          hpc_pkg::REG_OUTER: outer_r = cfg_data_i;
          hpc_pkg::REG_INNER: inner_r = cfg_data_i;
          hpc_pkg::REG_RATIO: ratio   = cfg_data_i;
          default: ;
        endcase
      end
    end
    pending_o = point_q.size();
  end

endmodule

// File: sim/hypocycloid_point_top_tb.sv
module hypocycloid_point_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IW = hpc_pkg::IW;
  localparam int RW = hpc_pkg::RW;
  localparam int PW = hpc_pkg::PW;
  localparam int OW = hpc_pkg::OW;

  localparam int            STAGES       = 16;
  localparam int            FRACS        = 16;
  localparam logic [IW-1:0] REG_SPARE    = 2'd3;
  localparam int            RAND_PHASES  = 10;
  localparam int            ITEMS_PER    = 150;
  localparam int            DRAIN_CYCLES = 40;
  localparam logic [RW-1:0] RMAX         = 24'hFFFFFF;

  localparam logic [PW-1:0] EDGE_PHASES [12] = '{
    32'h00000000, 32'h00003FFF, 32'h00004000, 32'h00007FFF, 32'h00008000, 32'h0000BFFF,
    32'h0000C000, 32'h0000FFFF, 32'h00010000, 32'hFFFFFFFF, 32'h80000000, 32'h00012345
  };

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  start;
  logic                  busy;
  logic [PW-1:0]         phase_i;
  logic                  done_o;
  logic signed [OW-1:0]  point_x_o;
  logic signed [OW-1:0]  point_y_o;
  logic                  cfg_we_i;
  logic [IW-1:0]         cfg_idx_i;
  logic [RW-1:0]         cfg_data_i;
  int                    mismatches;
  int                    pending;

  always #1 clk_i = ~clk_i;

  hypocycloid_point_top #(
    .CORDIC_STAGES(STAGES),
    .FRAC_BITS    (FRACS)
  ) u_top (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .busy      (busy),
    .phase_i   (phase_i),
    .done_o    (done_o),
    .point_x_o (point_x_o),
    .point_y_o (point_y_o),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  hypocycloid_point_checker #(
    .CORDIC_STAGES(STAGES),
    .FRAC_BITS    (FRACS)
  ) u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .busy_i        (busy),
    .phase_i       (phase_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .done_i        (done_o),
    .point_x_i     (point_x_o),
    .point_y_i     (point_y_o),
    .mismatch_cnt_o(mismatches),
    .pending_o     (pending)
  );

  // Leaves the write enable high so back-to-back writes need no toggle.
  task automatic write_reg(input logic [IW-1:0] idx, input logic [RW-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
  endtask

  // The spare index gets random data, which the block must ignore.
  task automatic load_radii(input logic [RW-1:0] big_r, input logic [RW-1:0] small_r,
                            input logic [RW-1:0] k);
    write_reg(hpc_pkg::REG_OUTER, big_r);
    write_reg(hpc_pkg::REG_INNER, small_r);
    write_reg(hpc_pkg::REG_RATIO, k);
    write_reg(REG_SPARE, RW'($urandom));
    cfg_we_i   <= 1'b0;
    cfg_data_i <= RW'($urandom);
    @(posedge clk_i);
  endtask

  task automatic drive_item(input logic [PW-1:0] ph);
    start   <= 1'b1;
    phase_i <= ph;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic idle_gap(input int pct);
    if ($urandom_range(0, 99) < pct) begin
      start   <= 1'b0;
      phase_i <= $urandom;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  function automatic logic [PW-1:0] rand_phase();
    logic [15:0] near;
    near = 16'(32'h4000 * $urandom_range(0, 3) + $urandom_range(0, 4) - 32'd2);
    case ($urandom_range(0, 5))
      0, 1:    return $urandom;
      2:       return {16'($urandom), near};
      3:       return $urandom_range(0, 65535);
      4:       return {16'hFFFF, 16'($urandom)};
      default: return {16'($urandom_range(0, 3)), 16'($urandom)};
    endcase
  endfunction

  function automatic logic [RW-1:0] pick_extreme();
    case ($urandom_range(0, 2))
      0:       return '0;
      1:       return RMAX;
      default: return RW'($urandom);
    endcase
  endfunction

  task automatic random_radii();
    logic [RW-1:0] big_r;
    logic [RW-1:0] small_r;
    logic [RW-1:0] k;
    int            n;
    case ($urandom_range(0, 3))
      0: begin
        big_r   = RW'($urandom);
        small_r = RW'($urandom);
        k       = RW'($urandom);
      end
      1: begin
        // A closed curve: R an integer multiple of r and k close to n - 1.
        n       = $urandom_range(2, 9);
        small_r = RW'($urandom_range(1, RMAX / n));
        big_r   = RW'(small_r * n);
        k       = RW'(((n - 1) << FRACS) | $urandom_range(0, 255));
      end
      2: begin
        small_r = RW'($urandom);
        big_r   = RW'($urandom_range(small_r, RMAX));
        k       = RW'($urandom_range(0, 24'h0FFFFF));
      end
      default: begin
        big_r   = pick_extreme();
        small_r = pick_extreme();
        k       = pick_extreme();
      end
    endcase
    load_radii(big_r, small_r, k);
  endtask

  initial begin
    rst_ni     <= 1'b0;
    start      <= 1'b0;
    phase_i    <= '0;
    cfg_we_i   <= 1'b0;
    cfg_idx_i  <= '0;
    cfg_data_i <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Registers still at their reset value.
    drive_item(32'h00002000);
    drain();

    load_radii(24'h050000, 24'h010000, 24'h040000);
    for (int i = 0; i < 12; i++) drive_item(EDGE_PHASES[i]);
    drain();

    // Rolling circle larger than the fixed one, with full ratio: saturates.
    load_radii('0, RMAX, RMAX);
    drive_item(32'h00000000);
    drive_item(32'h00008000);
    drive_item(32'h00004000);
    drive_item(32'hFFFFFFFF);
    drain();

    // Zero ratio keeps the second vector at angle zero.
    load_radii(RMAX, '0, '0);
    drive_item(32'h00000000);
    drive_item(32'h0000C000);
    drive_item(32'h5555AAAA);
    drain();

    load_radii(RMAX, RMAX, '0);
    drive_item(32'h00000000);
    drive_item(32'h00008000);
    drive_item(32'h0001FFFF);
    drain();

    for (int p = 0; p < RAND_PHASES; p++) begin
      int pct;
      random_radii();
      pct = (p == RAND_PHASES - 1) ? 0 : $urandom_range(0, 50);
      for (int i = 0; i < ITEMS_PER; i++) begin
        drive_item(rand_phase());
        idle_gap(pct);
      end
      drain();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// File: sim.f
src/hpc_pkg.sv
src/hpc_front.sv
src/hpc_cordic.sv
src/hpc_combine.sv
src/hypocycloid_point_top.sv
sim/hypocycloid_point_checker.sv
sim/hypocycloid_point_top_tb.sv
